>>> hw/rtl/spmf_pkg.sv
// Shared types and constants for the SPI master FIFO controller.
// No dependencies; all files but spmf_ram refer to it by scoped names.
package spmf_pkg;

	// Default sizes handed to the top level parameters
	localparam int unsigned FIFO_DEPTH_DEF   = 16;
	localparam int unsigned RX_THRESHOLD_DEF = 12;

	// Stream widths
	localparam int unsigned IN_W   = 40;
	localparam int unsigned USER_W = 4;
	localparam int unsigned OUT_W  = 40;

	// Operation codes carried in tuser[1:0]
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register selects carried in tuser[3:2]
	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_FIFO = 2'd1;
	localparam logic [1:0] REG_DIV  = 2'd2;
	localparam logic [1:0] REG_DLEN = 2'd3;

	// Control register bit positions
	localparam int unsigned CB_CPHA   = 2;
	localparam int unsigned CB_CPOL   = 3;
	localparam int unsigned CB_CLR_TX = 4;
	localparam int unsigned CB_CLR_RX = 5;
	localparam int unsigned CB_CSPOL  = 6;
	localparam int unsigned CB_TA     = 7;
	localparam int unsigned CB_INTD   = 9;
	localparam int unsigned CB_INTR   = 10;

	// Bits of the control word that are stored
	localparam logic [15:0] CTRL_WMASK = 16'h3FCF;

	// Decoded command kinds
	typedef enum logic [2:0] {
		K_NOP,
		K_TICK,
		K_WR_CTRL,
		K_WR_FIFO,
		K_WR_DIV,
		K_RD_STATUS,
		K_RD_FIFO,
		K_RD_DIV
	} cmd_kind_t;

	// One queued command from front to back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] wdata;
		logic        miso;
	} cmd_t;

	// One result; rdata sits in the lowest bits
	typedef struct packed {
		logic        done_res;
		logic        irq;
		logic [2:0]  cs_lines;
		logic        mosi;
		logic        sck;
		logic [31:0] rdata;
	} result_t;

endpackage

>>> hw/rtl/spmf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spmf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read-first storage
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/spmf_front.sv
// Front end: accepts stream transactions, decodes them into commands and
// holds them in a two-entry queue for the back end. Uses spmf_pkg.
module spmf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spmf_pkg::IN_W-1:0]     s_tdata,
	input  logic [spmf_pkg::USER_W-1:0]   s_tuser,
	output logic                          cmd_valid,
	output spmf_pkg::cmd_t                cmd,
	input  logic                          cmd_pop
);

	spmf_pkg::cmd_kind_t kind;
	spmf_pkg::cmd_t      cmd_in;
	spmf_pkg::cmd_t      queue_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                push;

	// Classify the transaction
	always_comb begin
		kind = spmf_pkg::K_NOP;
		case (s_tuser[1:0])
			spmf_pkg::OP_TICK: kind = spmf_pkg::K_TICK;
			spmf_pkg::OP_WRITE: begin
				case (s_tuser[3:2])
					spmf_pkg::REG_CTRL: kind = spmf_pkg::K_WR_CTRL;
					spmf_pkg::REG_FIFO: kind = spmf_pkg::K_WR_FIFO;
					spmf_pkg::REG_DIV:  kind = spmf_pkg::K_WR_DIV;
					spmf_pkg::REG_DLEN: kind = spmf_pkg::K_NOP;
					default:            kind = spmf_pkg::K_NOP;
				endcase
			end
			spmf_pkg::OP_READ: begin
				case (s_tuser[3:2])
					spmf_pkg::REG_CTRL: kind = spmf_pkg::K_RD_STATUS;
					spmf_pkg::REG_FIFO: kind = spmf_pkg::K_RD_FIFO;
					spmf_pkg::REG_DIV:  kind = spmf_pkg::K_RD_DIV;
					spmf_pkg::REG_DLEN: kind = spmf_pkg::K_NOP;
					default:            kind = spmf_pkg::K_NOP;
				endcase
			end
			default: kind = spmf_pkg::K_NOP;
		endcase
		cmd_in.kind  = kind;
		cmd_in.wdata = s_tdata[31:0];
		cmd_in.miso  = s_tdata[32];
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/spmf_back.sv
// Back end: control bits, TX/RX FIFOs, clock divider and byte shifter;
// executes one command per cycle into an output register while the
// receiver takes results. Uses spmf_pkg and spmf_ram.
module spmf_back #(
	parameter int unsigned FIFO_DEPTH   = spmf_pkg::FIFO_DEPTH_DEF,
	parameter int unsigned RX_THRESHOLD = spmf_pkg::RX_THRESHOLD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  spmf_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic              out_valid,
	input  logic              out_ready,
	output spmf_pkg::result_t out_data
);

	localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned LW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SW = LW + 1;
	localparam logic [LW-1:0] DEPTH_L = LW'(FIFO_DEPTH);
	localparam logic [7:0]    RXT_C   = 8'(RX_THRESHOLD);

	// Architectural state
	logic [15:0]   ctrl_q, ctrl_d;
	logic [15:0]   div_q, div_d;
	logic [PW-1:0] tx_head_q, tx_head_d, rx_head_q, rx_head_d;
	logic [LW-1:0] tx_level_q, tx_level_d, rx_level_q, rx_level_d;
	logic [7:0]    shift_q, shift_d;
	logic [3:0]    bit_q, bit_d;
	logic          busy_q, busy_d;
	logic [15:0]   cnt_q, cnt_d;
	logic          sck_q, sck_d;
	logic          sampled_q, sampled_d;

	// FIFO memory ports and read bypass
	logic          tx_we, rx_we;
	logic [PW-1:0] tx_waddr, rx_waddr;
	logic [7:0]    tx_wdata, rx_wdata;
	logic [7:0]    tx_rdata, rx_rdata;
	logic          tx_byp_q, rx_byp_q;
	logic [7:0]    tx_byp_data_q, rx_byp_data_q;
	logic [7:0]    tx_head_data, rx_head_data;

	// Output stage
	logic              out_valid_q;
	spmf_pkg::result_t out_data_q;
	spmf_pkg::result_t result;
	logic              fire;

	logic [15:0] half;
	logic [15:0] cnt_inc;
	logic [15:0] new_ctrl;
	logic        done_d, rxr_d, active;

	function automatic logic [PW-1:0] wrap_sum(logic [PW-1:0] head, logic [LW-1:0] lvl);
		logic [SW-1:0] s;
		s = SW'(head) + SW'(lvl);
		if (s >= SW'(FIFO_DEPTH)) begin
			s = s - SW'(FIFO_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	spmf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (tx_wdata),
		.raddr (tx_head_d),
		.rdata (tx_rdata)
	);

	spmf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr),
		.wdata (rx_wdata),
		.raddr (rx_head_d),
		.rdata (rx_rdata)
	);

	assign tx_head_data = tx_byp_q ? tx_byp_data_q : tx_rdata;
	assign rx_head_data = rx_byp_q ? rx_byp_data_q : rx_rdata;

	// Half SCK period; divider zero means 65536
	always_comb begin
		if (div_q == 16'd0) begin
			half = 16'h8000;
		end else if (div_q[15:1] == 15'd0) begin
			half = 16'd1;
		end else begin
			half = {1'b0, div_q[15:1]};
		end
	end

	assign fire    = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_pop = fire;
	assign cnt_inc = cnt_q + 16'd1;

	// Command execution and next state
	always_comb begin
		ctrl_d     = ctrl_q;
		div_d      = div_q;
		tx_head_d  = tx_head_q;
		rx_head_d  = rx_head_q;
		tx_level_d = tx_level_q;
		rx_level_d = rx_level_q;
		shift_d    = shift_q;
		bit_d      = bit_q;
		busy_d     = busy_q;
		cnt_d      = cnt_q;
		sck_d      = sck_q;
		sampled_d  = sampled_q;
		tx_we      = 1'b0;
		tx_waddr   = wrap_sum(tx_head_q, tx_level_q);
		tx_wdata   = cmd.wdata[7:0];
		rx_we      = 1'b0;
		rx_waddr   = wrap_sum(rx_head_q, rx_level_q);
		rx_wdata   = 8'd0;
		new_ctrl   = cmd.wdata[15:0] & spmf_pkg::CTRL_WMASK;
		result.rdata = 32'd0;

		if (fire) begin
			case (cmd.kind)
				spmf_pkg::K_TICK: begin
					if (ctrl_q[spmf_pkg::CB_TA]) begin
						if (!busy_q) begin
							// load the oldest TX byte
							if (tx_level_q != '0) begin
								shift_d    = tx_head_data;
								tx_head_d  = wrap_sum(tx_head_q, LW'(1));
								tx_level_d = tx_level_q - LW'(1);
								busy_d     = 1'b1;
								bit_d      = 4'd0;
								cnt_d      = 16'd0;
								sampled_d  = 1'b0;
								sck_d      = ctrl_q[spmf_pkg::CB_CPOL];
							end
						end else if (cnt_inc >= half) begin
							// SCK edge: even edges lead, odd edges trail
							cnt_d = 16'd0;
							sck_d = ~sck_q;
							if (!ctrl_q[spmf_pkg::CB_CPHA]) begin
								if (!bit_q[0]) begin
									sampled_d = cmd.miso;
								end else begin
									shift_d = {shift_q[6:0], sampled_q};
								end
							end else begin
								if (!bit_q[0]) begin
									if (bit_q != 4'd0) begin
										shift_d = {shift_q[6:0], sampled_q};
									end
								end else begin
									sampled_d = cmd.miso;
									if (bit_q == 4'hF) begin
										shift_d = {shift_q[6:0], cmd.miso};
									end
								end
							end
							if (bit_q == 4'hF) begin
								// byte complete; dropped when RX is full
								if (rx_level_q < DEPTH_L) begin
									rx_we      = 1'b1;
									rx_wdata   = shift_d;
									rx_level_d = rx_level_q + LW'(1);
								end
								busy_d = 1'b0;
								bit_d  = 4'd0;
							end else begin
								bit_d = bit_q + 4'd1;
							end
						end else begin
							cnt_d = cnt_inc;
						end
					end
				end
				spmf_pkg::K_WR_CTRL: begin
					if (cmd.wdata[spmf_pkg::CB_CLR_TX]) begin
						tx_level_d = '0;
						tx_head_d  = '0;
					end
					if (cmd.wdata[spmf_pkg::CB_CLR_RX]) begin
						rx_level_d = '0;
						rx_head_d  = '0;
					end
					// clearing TA aborts a byte in flight
					if (ctrl_q[spmf_pkg::CB_TA] && !new_ctrl[spmf_pkg::CB_TA]) begin
						busy_d = 1'b0;
						bit_d  = 4'd0;
						cnt_d  = 16'd0;
					end
					ctrl_d = new_ctrl;
				end
				spmf_pkg::K_WR_FIFO: begin
					if (tx_level_q < DEPTH_L) begin
						tx_we      = 1'b1;
						tx_level_d = tx_level_q + LW'(1);
					end
				end
				spmf_pkg::K_WR_DIV: begin
					div_d = cmd.wdata[15:0];
				end
				spmf_pkg::K_RD_STATUS: begin
					result.rdata = {11'd0,
						(rx_level_q == DEPTH_L),
						(8'(rx_level_q) >= RXT_C),
						(tx_level_q < DEPTH_L),
						(rx_level_q != '0),
						(ctrl_q[spmf_pkg::CB_TA] && tx_level_q == '0 && !busy_q),
						ctrl_q};
				end
				spmf_pkg::K_RD_FIFO: begin
					if (rx_level_q != '0) begin
						result.rdata = {24'd0, rx_head_data};
						rx_head_d    = wrap_sum(rx_head_q, LW'(1));
						rx_level_d   = rx_level_q - LW'(1);
					end
				end
				spmf_pkg::K_RD_DIV: begin
					result.rdata = {16'd0, div_q};
				end
				default: begin
				end
			endcase
		end

		if (cfg_we) begin
			div_d = cfg_wdata;
		end

		// Line levels and flags after the step
		result.sck  = busy_d ? sck_d : ctrl_d[spmf_pkg::CB_CPOL];
		result.mosi = busy_d & shift_d[7];
		for (int i = 0; i < 3; i++) begin
			active = ctrl_d[spmf_pkg::CB_TA] && (ctrl_d[1:0] == 2'(i));
			result.cs_lines[i] = (active == ctrl_d[spmf_pkg::CB_CSPOL]);
		end
		done_d = ctrl_d[spmf_pkg::CB_TA] && (tx_level_d == '0) && !busy_d;
		rxr_d  = (8'(rx_level_d) >= RXT_C);
		result.done_res = done_d;
		result.irq = (ctrl_d[spmf_pkg::CB_INTD] && done_d) ||
			(ctrl_d[spmf_pkg::CB_INTR] && rxr_d);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= 16'd0;
			div_q       <= 16'd0;
			tx_head_q   <= '0;
			rx_head_q   <= '0;
			tx_level_q  <= '0;
			rx_level_q  <= '0;
			shift_q     <= 8'd0;
			bit_q       <= 4'd0;
			busy_q      <= 1'b0;
			cnt_q       <= 16'd0;
			sck_q       <= 1'b0;
			sampled_q   <= 1'b0;
			tx_byp_q    <= 1'b0;
			rx_byp_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ctrl_q     <= ctrl_d;
			div_q      <= div_d;
			tx_head_q  <= tx_head_d;
			rx_head_q  <= rx_head_d;
			tx_level_q <= tx_level_d;
			rx_level_q <= rx_level_d;
			shift_q    <= shift_d;
			bit_q      <= bit_d;
			busy_q     <= busy_d;
			cnt_q      <= cnt_d;
			sck_q      <= sck_d;
			sampled_q  <= sampled_d;
			tx_byp_q   <= tx_we && (tx_waddr == tx_head_d);
			rx_byp_q   <= rx_we && (rx_waddr == rx_head_d);
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		tx_byp_data_q <= tx_wdata;
		rx_byp_data_q <= rx_wdata;
		if (fire) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_tx_level: assert property (@(posedge clk) disable iff (!arst_n)
		tx_level_q <= DEPTH_L)
		else $error("TX level above FIFO depth");
	a_rx_level: assert property (@(posedge clk) disable iff (!arst_n)
		rx_level_q <= DEPTH_L)
		else $error("RX level above FIFO depth");
	a_busy_ta: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ctrl_q[spmf_pkg::CB_TA])
		else $error("shifter busy with transfer inactive");
	a_idle_bit: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (bit_q == 4'd0))
		else $error("bit index not cleared while idle");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cnt_q[15])
		else $error("divide count out of range");

endmodule

>>> hw/rtl/spi_master_fifo_controller_core.sv
// Top level of the SPI master FIFO controller: front end, command queue and
// back end. Depends on spmf_pkg, spmf_front, spmf_back and spmf_ram.
//
// Usage: each slave-side transaction carries one bus read, one bus write or
// one core clock tick (tuser op), with the register select in tuser and the
// write data and the MISO sample in tdata. Every accepted transaction gives
// exactly one master-side transaction with the read data and the SCK, MOSI,
// chip select, IRQ and DONE levels as they stand after that step.
// The clock divider may also be loaded through cfg_we/cfg_wdata while idle.
// Each transaction passes the command queue and then the output register.
// Throughput: one transaction per cycle unless the receiver stalls; the back
// end executes a whole step, including FIFO access through registered-read
// RAMs with a write bypass, as one state update. SCK speed is set by the
// divider counting tick transactions. Reset clears control bits, FIFO levels
// and pointers, the shifter and the divider (which then means 65536); FIFO
// contents are left as they are. When the receiver stalls, the result waits
// in the output register, the two-entry queue fills behind it and
// s_axis_tready then drops until the result is taken.
module spi_master_fifo_controller_core #(
	parameter int unsigned FIFO_DEPTH   = spmf_pkg::FIFO_DEPTH_DEF,
	parameter int unsigned RX_THRESHOLD = spmf_pkg::RX_THRESHOLD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [31:0] wdata, [32] miso, [39:33] zero
	input  logic [spmf_pkg::IN_W-1:0]    s_axis_tdata,
	// [1:0] op, [3:2] reg_sel
	input  logic [spmf_pkg::USER_W-1:0]  s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [31:0] rdata, [32] sck, [33] mosi, [36:34] cs_lines, [37] irq,
	// [38] done_res, [39] zero
	output logic [spmf_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                         cfg_we,
	input  logic [15:0]                  cfg_wdata
);

	logic              cmd_valid;
	logic              cmd_pop;
	spmf_pkg::cmd_t    cmd;
	spmf_pkg::result_t out_data;

	spmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	spmf_back #(
		.FIFO_DEPTH   (FIFO_DEPTH),
		.RX_THRESHOLD (RX_THRESHOLD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	assign m_axis_tdata = {1'b0, out_data};

endmodule

>>> sim/spi_master_fifo_controller_core_tb.sv
// Self-checking testbench for the SPI master FIFO controller core.
// Needs spmf_pkg and the core RTL; a bit-true predictor checks every result beat.
`timescale 1ns / 100ps

module spi_master_fifo_controller_core_tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DEPTH          = spmf_pkg::FIFO_DEPTH_DEF;
	localparam int RX_THR         = spmf_pkg::RX_THRESHOLD_DEF;
	localparam int PTR_W          = $clog2(DEPTH);

	// Op code the block treats as a no-operation
	localparam logic [1:0] OP_NONE = 2'd3;

	// Control words built from named bits
	localparam logic [31:0] C_TA    = 32'd1 << spmf_pkg::CB_TA;
	localparam logic [31:0] C_CSPOL = 32'd1 << spmf_pkg::CB_CSPOL;
	localparam logic [31:0] C_CLR   = (32'd1 << spmf_pkg::CB_CLR_TX) |
		(32'd1 << spmf_pkg::CB_CLR_RX);

	typedef struct {
		logic [1:0]  op;
		logic [1:0]  rsel;
		logic [31:0] wd;
		logic        miso;
	} bus_op_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [spmf_pkg::IN_W-1:0]     s_axis_tdata  = '0;
	logic [spmf_pkg::USER_W-1:0]   s_axis_tuser  = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [spmf_pkg::OUT_W-1:0]    m_axis_tdata;
	logic                          cfg_we        = 1'b0;
	logic [15:0]                   cfg_wdata     = '0;

	spi_master_fifo_controller_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stimulus and expectation stores
	bus_op_t           bus_ops[$];
	spmf_pkg::result_t line_states[$];
	bus_op_t           cur_op;
	spmf_pkg::result_t head_line;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int tick_half      = 1;
	int ops_queued     = 0;
	int ops_accepted   = 0;
	int lines_checked  = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;
	int bytes_rx       = 0;
	int tx_drops       = 0;
	int rx_drops       = 0;

	// Predictor state
	logic [15:0] div_reg  = '0;
	logic [15:0] ctl_reg  = '0;
	logic [7:0]  tx_mem[DEPTH];
	logic [7:0]  rx_mem[DEPTH];
	int          tx_lvl   = 0;
	int          rx_lvl   = 0;
	int          tx_head  = 0;
	int          rx_head  = 0;
	logic [7:0]  shf_byte = '0;
	logic [3:0]  bit_cnt  = '0;
	logic        shf_busy = 1'b0;
	int          div_cnt  = 0;
	logic        sck_lvl  = 1'b0;
	logic        miso_smp = 1'b0;

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			tx_mem[i] = '0;
			rx_mem[i] = '0;
		end
	end

	function automatic logic xfer_done();
		return ctl_reg[spmf_pkg::CB_TA] && tx_lvl == 0 && !shf_busy;
	endfunction

	function automatic void rx_push_byte();
		if (rx_lvl < DEPTH) begin
			rx_mem[PTR_W'((rx_head + rx_lvl) % DEPTH)] = shf_byte;
			rx_lvl++;
			bytes_rx++;
		end else begin
			rx_drops++;
		end
	endfunction

	// One bus step of the SPI master; returns read data and line levels after it
	function automatic spmf_pkg::result_t advance_spi(bus_op_t b);
		spmf_pkg::result_t r;
		logic [15:0]       nc;
		logic [3:0]        e;
		int                half;
		r = '0;
		case (b.op)
			spmf_pkg::OP_TICK: if (ctl_reg[spmf_pkg::CB_TA]) begin
				if (!shf_busy) begin
					// load the oldest TX byte
					if (tx_lvl != 0) begin
						shf_byte = tx_mem[PTR_W'(tx_head)];
						tx_head  = (tx_head + 1) % DEPTH;
						tx_lvl--;
						shf_busy = 1'b1;
						bit_cnt  = '0;
						div_cnt  = 0;
						miso_smp = 1'b0;
						sck_lvl  = ctl_reg[spmf_pkg::CB_CPOL];
					end
				end else begin
					half = (div_reg == 16'd0) ? 32768 : (int'(div_reg) >> 1);
					if (half == 0)
						half = 1;
					div_cnt++;
					if (div_cnt >= half) begin
						// SCK transition; even count is the leading one
						div_cnt = 0;
						e       = bit_cnt;
						sck_lvl = !sck_lvl;
						if (!ctl_reg[spmf_pkg::CB_CPHA]) begin
							if (!e[0])
								miso_smp = b.miso;
							else
								shf_byte = {shf_byte[6:0], miso_smp};
						end else if (!e[0]) begin
							if (e != 4'd0)
								shf_byte = {shf_byte[6:0], miso_smp};
						end else begin
							miso_smp = b.miso;
							if (e == 4'd15)
								shf_byte = {shf_byte[6:0], miso_smp};
						end
						if (e == 4'd15) begin
							rx_push_byte();
							shf_busy = 1'b0;
							bit_cnt  = '0;
							div_cnt  = 0;
						end else begin
							bit_cnt = e + 4'd1;
						end
					end
				end
			end
			spmf_pkg::OP_WRITE: case (b.rsel)
				spmf_pkg::REG_CTRL: begin
					nc = b.wd[15:0] & spmf_pkg::CTRL_WMASK;
					if (b.wd[spmf_pkg::CB_CLR_TX]) begin
						tx_lvl  = 0;
						tx_head = 0;
					end
					if (b.wd[spmf_pkg::CB_CLR_RX]) begin
						rx_lvl  = 0;
						rx_head = 0;
					end
					// dropping TA kills a byte in flight
					if (ctl_reg[spmf_pkg::CB_TA] && !nc[spmf_pkg::CB_TA]) begin
						shf_busy = 1'b0;
						bit_cnt  = '0;
						div_cnt  = 0;
					end
					ctl_reg = nc;
				end
				spmf_pkg::REG_FIFO: begin
					if (tx_lvl < DEPTH) begin
						tx_mem[PTR_W'((tx_head + tx_lvl) % DEPTH)] = b.wd[7:0];
						tx_lvl++;
					end else begin
						tx_drops++;
					end
				end
				spmf_pkg::REG_DIV: div_reg = b.wd[15:0];
				default: ;
			endcase
			spmf_pkg::OP_READ: case (b.rsel)
				spmf_pkg::REG_CTRL: r.rdata = {11'd0, rx_lvl == DEPTH, rx_lvl >= RX_THR,
					tx_lvl < DEPTH, rx_lvl > 0, xfer_done(), ctl_reg};
				spmf_pkg::REG_FIFO: if (rx_lvl > 0) begin
					r.rdata = {24'd0, rx_mem[PTR_W'(rx_head)]};
					rx_head = (rx_head + 1) % DEPTH;
					rx_lvl--;
				end
				spmf_pkg::REG_DIV:  r.rdata = {16'd0, div_reg};
				default: ;
			endcase
			default: ;
		endcase

		// line levels after the step
		r.sck  = shf_busy ? sck_lvl : ctl_reg[spmf_pkg::CB_CPOL];
		r.mosi = shf_busy & shf_byte[7];
		for (int i = 0; i < 3; i++)
			r.cs_lines[i] = ((ctl_reg[spmf_pkg::CB_TA] && ctl_reg[1:0] == 2'(i)) ==
				ctl_reg[spmf_pkg::CB_CSPOL]);
		r.irq      = (ctl_reg[spmf_pkg::CB_INTD] && xfer_done()) ||
			(ctl_reg[spmf_pkg::CB_INTR] && rx_lvl >= RX_THR);
		r.done_res = xfer_done();
		return r;
	endfunction

	// Driver: presents queued bus ops, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				line_states.push_back(advance_spi(cur_op));
				ops_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (bus_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_op = bus_ops.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {7'd0, cur_op.miso, cur_op.wd};
					s_axis_tuser  <= {cur_op.rsel, cur_op.op};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_mismatch(input string what, input spmf_pkg::result_t want,
			input logic [spmf_pkg::OUT_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: rdata %h/%h sck %b/%b mosi %b/%b cs %b/%b %s %b/%b %s %b/%b %s",
				$time, what, want.rdata, got[31:0], want.sck, got[32], want.mosi,
				got[33], want.cs_lines, got[36:34], "irq", want.irq, got[37],
				"done", want.done_res, got[38], $sformatf("pad %b (exp/got)", got[39]));
	endtask

	// Monitor: random back-pressure, compares each result beat in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_states.size() == 0) begin
					flag_mismatch("unexpected result", '0, m_axis_tdata);
				end else begin
					head_line = line_states.pop_front();
					lines_checked++;
					if (m_axis_tdata !== {1'b0, head_line})
						flag_mismatch("result mismatch", head_line, m_axis_tdata);
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("spi_master_fifo_controller_core test failed");
			$finish;
		end
	end

	task automatic push_op(input logic [1:0] op, input logic [1:0] rsel, input logic [31:0] wd);
		bus_op_t b;
		b.op   = op;
		b.rsel = rsel;
		b.wd   = wd;
		b.miso = 1'($urandom_range(0, 1));
		bus_ops.push_back(b);
		ops_queued++;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (bus_ops.size() != 0 || s_axis_tvalid || line_states.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_divider(input logic [15:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		div_reg   = v;
	endtask

	// Random bus ops; divider writes mostly keep SCK fast
	task automatic gen_noise(input int n);
		logic [1:0]  op;
		logic [1:0]  rsel;
		logic [31:0] wd;
		for (int i = 0; i < n; i++) begin
			op   = 2'($urandom_range(0, 3));
			rsel = 2'($urandom_range(0, 3));
			wd   = $urandom;
			if (op == spmf_pkg::OP_WRITE && rsel == spmf_pkg::REG_DIV &&
					$urandom_range(0, 7) != 0)
				wd[15:0] = 16'($urandom_range(1, 7));
			push_op(op, rsel, wd);
		end
	endtask

	// One SPI burst: mode word with TA, fill TX, tick it out with optional
	// interleaved accesses, then drain some RX bytes
	task automatic gen_burst(input int nbytes, input bit clears_ok, input bit div_ok,
			input int noise_pct, input int reads_after);
		logic [31:0] w;
		logic [15:0] d;
		int          ticks;
		int          pick;
		w = $urandom;
		w[spmf_pkg::CB_TA]     = 1'b1;
		w[spmf_pkg::CB_CLR_TX] = clears_ok && $urandom_range(0, 3) == 0;
		w[spmf_pkg::CB_CLR_RX] = clears_ok && $urandom_range(0, 3) == 0;
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, w);
		if (div_ok && $urandom_range(0, 1) != 0) begin
			d = 16'($urandom_range(1, 7));
			push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_DIV,
				{16'($urandom_range(0, 65535)), d});
			tick_half = ((d >> 1) == 16'd0) ? 1 : int'(d >> 1);
		end
		for (int i = 0; i < nbytes; i++)
			push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_FIFO, $urandom);
		ticks = nbytes * (16 * tick_half + 1) + $urandom_range(0, 4);
		for (int i = 0; i < ticks; i++) begin
			pick = $urandom_range(0, 99);
			if (pick >= noise_pct)
				push_op(spmf_pkg::OP_TICK, 2'($urandom_range(0, 3)), $urandom);
			else if (pick < noise_pct / 3)
				push_op(spmf_pkg::OP_READ, spmf_pkg::REG_CTRL, $urandom);
			else if (pick < 2 * noise_pct / 3)
				push_op(spmf_pkg::OP_READ, spmf_pkg::REG_FIFO, $urandom);
			else if (pick == noise_pct - 1)
				push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, $urandom);
			else
				gen_noise(1);
		end
		for (int i = 0; i < reads_after; i++)
			push_op(spmf_pkg::OP_READ, spmf_pkg::REG_FIFO, $urandom);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_CTRL, $urandom);
	endtask

	task automatic run_random_phase(input int target);
		int start;
		int n;
		int pick;
		start = ops_queued;
		while (ops_queued - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				n = $urandom_range(1, 2);
				gen_burst(n, 1'b1, 1'b1, 12, $urandom_range(0, n + 1));
			end else if (pick < 90) begin
				gen_noise($urandom_range(3, 10));
			end else begin
				n = $urandom_range(3, 4);
				gen_burst(n, 1'b1, 1'b0, 5, n + 2);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, every register, chip selects, abort
		send_idle_pct  = 21;
		recv_stall_pct = 63;
		load_divider(16'hFFFF);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_CTRL, '0);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_FIFO, '0);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_DIV, '0);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_DLEN, '0);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_DLEN, '1);
		push_op(OP_NONE, spmf_pkg::REG_DLEN, '1);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_DIV, 32'hFFFF_0000);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_DIV, '1);
		// all bits set: TA on reserved chip select, FIFOs cleared
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, '1);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_CTRL, '0);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_FIFO, 32'h0000_00FF);
		push_op(spmf_pkg::OP_TICK, spmf_pkg::REG_CTRL, '0);
		push_op(spmf_pkg::OP_TICK, spmf_pkg::REG_FIFO, '1);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_CTRL, '0);
		// TA dropped mid-byte, then a tick with TA clear
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, '0);
		push_op(spmf_pkg::OP_TICK, spmf_pkg::REG_CTRL, '0);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, C_TA);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, C_TA | C_CSPOL | 32'd1);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, C_TA | 32'd2);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_CTRL, C_CLR);
		push_op(spmf_pkg::OP_WRITE, spmf_pkg::REG_DIV, 32'h0000_0001);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_CTRL, '0);

		// fastest SCK; overfill TX and fill RX, then overflow RX and drain past empty
		load_divider(16'd1);
		tick_half = 1;
		gen_burst(DEPTH + 1, 1'b0, 1'b0, 0, 0);
		gen_burst(1, 1'b0, 1'b0, 0, DEPTH + 2);
		run_random_phase(20);

		send_idle_pct  = 63;
		recv_stall_pct = 21;
		load_divider(16'd3);
		tick_half = 1;
		run_random_phase(50);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		load_divider(16'd4);
		tick_half = 2;
		run_random_phase(50);

		// divider zero means the longest period
		load_divider(16'd0);
		push_op(spmf_pkg::OP_READ, spmf_pkg::REG_DIV, '0);
		gen_noise(6);

		wait_idle();
		repeat (4) @(posedge clk);
		$display("%0d bus transactions, %0d results checked; %0d bytes shifted into RX,",
			ops_accepted, lines_checked, bytes_rx);
		$display("%0d TX writes and %0d RX bytes dropped on full FIFOs, %0d mismatches",
			tx_drops, rx_drops, mismatches);
		if (mismatches == 0 && line_states.size() == 0)
			$display("spi_master_fifo_controller_core test passed");
		else
			$display("spi_master_fifo_controller_core test failed");
		$finish;
	end

endmodule
